// File: hw/rtl/alfp_pkg.sv
// ----------------------------------------------------------------------------
// alfp_pkg: shared types and constants of the active-line field parser
// Phase codes, character codes, number widths and the item/result structs.
// ----------------------------------------------------------------------------
package alfp_pkg;

  // Width of the parsed numbers (signed range of NUMBER_BITS bits)
  localparam int NUMBER_BITS = 64;
  // Digit accumulator: magnitude * 10 + 9 always fits in four more bits
  localparam int ACC_BITS    = NUMBER_BITS + 4;
  // Fixed width of the result ports
  localparam int MARK_BITS   = 64;

  // Parser phases
  localparam int PHASE_BITS = 3;
  localparam logic [PHASE_BITS-1:0] PH_SKIP_HI = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_SIGN_HI = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_DIG_HI  = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_SKIP_LO = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_SIGN_LO = 3'd4;
  localparam logic [PHASE_BITS-1:0] PH_DIG_LO  = 3'd5;
  localparam logic [PHASE_BITS-1:0] PH_SKIP_ST = 3'd6;
  localparam logic [PHASE_BITS-1:0] PH_DONE    = 3'd7;

  // Character codes
  localparam logic [7:0] CH_MINUS       = 8'd45;
  localparam logic [7:0] STATUS_DEFAULT = 8'd121;  // 'y'

  // Register map (byte addresses)
  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] ADDR_TWO_MARKS = 3'd0;

  // One input item
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       line_end;
  } item_t;

  // One result item
  typedef struct packed {
    logic [MARK_BITS-1:0] high_mark;
    logic [MARK_BITS-1:0] low_mark;
    logic [7:0]           status_char;
  } result_t;

endpackage

// File: hw/rtl/alfp_parse.sv
// ----------------------------------------------------------------------------
// alfp_parse: line parsing state and per-byte update
// Holds the line state and advances it by one registered item per cycle while go
// is high; produces the result of a line in the same cycle as its end marker.
// ----------------------------------------------------------------------------
module alfp_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,            // item in the input register advances
  input  alfp_pkg::item_t item,
  input  logic            two_marks,
  output logic            res_valid,
  output alfp_pkg::result_t res
);
  import alfp_pkg::*;

  // Line state
  logic [PHASE_BITS-1:0]  phase, phase_next;
  logic [NUMBER_BITS-1:0] magnitude, magnitude_next;
  logic                   negative, negative_next;
  logic [NUMBER_BITS-1:0] high_value, high_value_next;
  logic [NUMBER_BITS-1:0] low_value, low_value_next;
  logic [7:0]             status_value, status_value_next;

  // Byte class
  logic is_space, is_digit;
  always_comb begin
    is_space = (item.ch == 8'd32) || (item.ch inside {[8'd9:8'd13]});
    is_digit = item.ch inside {[8'd48:8'd57]};
  end

  // Digit accumulator: base * 10 + d, checked against the signed limit.
  // A digit opens a number from zero in a skip phase, continues otherwise.
  logic                   in_skip, in_sign, dig_neg, ovf;
  logic [ACC_BITS-1:0]    base, acc, limit;
  always_comb begin
    in_skip = (phase == PH_SKIP_HI) || (phase == PH_SKIP_LO);
    in_sign = (phase == PH_SIGN_HI) || (phase == PH_SIGN_LO);
    dig_neg = in_sign ? 1'b1 : (in_skip ? 1'b0 : negative);
    base    = in_skip ? '0 : ACC_BITS'(magnitude);
    acc     = (base << 3) + (base << 1) + ACC_BITS'(item.ch[3:0]);
    limit   = (ACC_BITS'(1) << (NUMBER_BITS - 1)) - ACC_BITS'(!dig_neg);
    ovf     = acc > limit;
  end

  // Signed value of the number being read, before and after this byte
  logic [NUMBER_BITS-1:0] sval_cur, sval_end;
  assign sval_cur = negative ? (NUMBER_BITS'(0) - magnitude) : magnitude;
  assign sval_end = negative_next ? (NUMBER_BITS'(0) - magnitude_next) : magnitude_next;

  // Per-item update
  logic [PHASE_BITS-1:0] pe;   // phase after a number ends on this byte
  logic                  clear;
  always_comb begin
    pe                = phase;
    phase_next        = phase;
    magnitude_next    = magnitude;
    negative_next     = negative;
    high_value_next   = high_value;
    low_value_next    = low_value;
    status_value_next = status_value;

    if (item.has_char) begin
      // a non-digit ends a number; the byte is then handled by the next phase
      if (((phase == PH_DIG_HI) || (phase == PH_DIG_LO)) && !is_digit) begin
        if (phase == PH_DIG_HI) begin
          high_value_next = sval_cur;
          pe = two_marks ? PH_SKIP_LO : PH_SKIP_ST;
        end else begin
          low_value_next = sval_cur;
          pe = PH_SKIP_ST;
        end
        magnitude_next = '0;
        negative_next  = 1'b0;
      end
      phase_next = pe;

      case (pe)
        PH_SKIP_HI, PH_SKIP_LO: begin
          if (!is_space) begin
            magnitude_next = '0;
            negative_next  = 1'b0;
            if (item.ch == CH_MINUS) begin
              negative_next = 1'b1;
              phase_next = (pe == PH_SKIP_HI) ? PH_SIGN_HI : PH_SIGN_LO;
            end else if (!is_digit) begin
              phase_next = PH_DONE;
            end else if (ovf) begin
              phase_next = PH_DONE;
            end else begin
              phase_next     = (pe == PH_SKIP_HI) ? PH_DIG_HI : PH_DIG_LO;
              magnitude_next = acc[NUMBER_BITS-1:0];
            end
          end
        end
        PH_SIGN_HI, PH_SIGN_LO: begin
          if (!is_digit || ovf) begin
            phase_next = PH_DONE;
          end else begin
            phase_next     = (pe == PH_SIGN_HI) ? PH_DIG_HI : PH_DIG_LO;
            magnitude_next = acc[NUMBER_BITS-1:0];
          end
        end
        PH_DIG_HI, PH_DIG_LO: begin
          // only digits reach here
          if (ovf) begin
            phase_next = PH_DONE;
          end else begin
            magnitude_next = acc[NUMBER_BITS-1:0];
          end
        end
        PH_SKIP_ST: begin
          if (!is_space) begin
            status_value_next = item.ch;
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    // line end: finish an open number and report
    res.high_mark   = MARK_BITS'($signed(high_value_next));
    res.low_mark    = MARK_BITS'($signed(low_value_next));
    res.status_char = status_value_next;
    if (phase_next == PH_DIG_HI) begin
      res.high_mark = MARK_BITS'($signed(sval_end));
    end else if (phase_next == PH_DIG_LO) begin
      res.low_mark = MARK_BITS'($signed(sval_end));
    end
  end

  assign res_valid = go && item.line_end;
  assign clear     = res_valid;

  // State registers
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase        <= PH_SKIP_HI;
      magnitude    <= '0;
      negative     <= 1'b0;
      high_value   <= '0;
      low_value    <= NUMBER_BITS'(1);
      status_value <= STATUS_DEFAULT;
    end else if (go) begin
      phase        <= phase_next;
      magnitude    <= magnitude_next;
      negative     <= negative_next;
      high_value   <= high_value_next;
      low_value    <= low_value_next;
      status_value <= status_value_next;
    end
  end

  // A reported line leaves the parser in its start state
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (phase == PH_SKIP_HI) && (status_value == STATUS_DEFAULT)
                  && (magnitude == '0) && !negative)
    else $error("line state not cleared after line end");

  // Once parsing stops, only a line end leaves the done phase
  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) && !res_valid |=> phase == PH_DONE)
    else $error("left done phase without line end");

  // No partial number is held while waiting for one to start
  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP_HI) || (phase == PH_SKIP_LO) |-> (magnitude == '0) && !negative)
    else $error("stale magnitude in skip phase");

endmodule

// File: hw/rtl/active_line_field_parser_top.sv
// ----------------------------------------------------------------------------
// active_line_field_parser_top: news active-line field parser
// Takes field text one byte per item, returns high mark, low mark and status
// character at each line end; one configuration register over APB.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, ch, has_char, line_end | into block
//  out     | out_valid, out_stall, high_mark, low_mark, | out of block
//          | status_char                              |
//  cfg     | psel, penable, pwrite, paddr, pwdata,    | APB slave
//          | prdata, pready                           |
//
//  One item per cycle sustained while in_stall is low. Items pass through the
//  input register, then the line state update and the result register.
//  The per-byte update is a shift-add by ten and a compare against the limit.
//  Reset (synchronous): two_marks = 1, line state cleared, both stages empty.
//  out_stall holds the result register; in_stall rises only when a line end
//  waits behind a full, stalled result register.
// ----------------------------------------------------------------------------
module active_line_field_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      ch,
  input  logic                            has_char,
  input  logic                            line_end,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [alfp_pkg::MARK_BITS-1:0] high_mark,
  output logic signed [alfp_pkg::MARK_BITS-1:0] low_mark,
  output logic [7:0]                      status_char,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [alfp_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import alfp_pkg::*;

  // Configuration register
  logic two_marks;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      two_marks <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_TWO_MARKS)) begin
      two_marks <= pwdata[0];
    end
  end
  assign prdata = (paddr == ADDR_TWO_MARKS) ? {31'b0, two_marks} : 32'b0;

  // Input register
  item_t in_q;
  logic  in_q_valid;
  logic  go;
  assign go       = in_q_valid && (!in_q.line_end || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (go) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q.ch       <= ch;
      in_q.has_char <= has_char;
      in_q.line_end <= line_end;
    end
  end

  // Line state and per-byte update
  logic    res_valid;
  result_t res;
  alfp_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .item         (in_q),
    .two_marks    (two_marks),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      high_mark   <= res.high_mark;
      low_mark    <= res.low_mark;
      status_char <= res.status_char;
    end
  end

  // A line end never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !res_valid)
    else $error("result register overwritten while stalled");

  // A line end held back by the output stays in the input register
  a_end_held: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && in_q.line_end && out_valid && out_stall |=> in_q_valid && in_q.line_end)
    else $error("pending line end lost");

endmodule
